@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the core modules.
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DVC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("core assertion failed");

// Next-cycle implication.
`define DVC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("core assertion failed");

`endif

@@ rtl/core/dvc_pkg.sv @@
`default_nettype none

package dvc_pkg;

  localparam int VALUE_W     = 32;
  localparam int OCC_W       = 7;
  localparam int DEPTH_DEF   = 64;
  localparam int MAX_RESULTS = 32;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
  localparam logic [OCC_W-1:0] OCC_MAX = {OCC_W{1'b1}};

  // Probe that travels down the cell row, counting copies of one value
  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    logic [OCC_W-1:0]   cnt;
  } probe_t;

  // Controls broadcast to every cell
  typedef struct packed {
    logic load;
    logic step;
    logic clear;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/dvc_ifs.sv @@
`default_nettype none

interface dvc_in_if;
  logic                        valid;
  logic                        ready;
  logic [dvc_pkg::VALUE_W-1:0] value;
  logic                        last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

interface dvc_out_if;
  logic                        valid;
  logic                        ready;
  logic [dvc_pkg::VALUE_W-1:0] dup_value;
  logic [dvc_pkg::OCC_W-1:0]   occurrences;
  logic                        final_res;
  logic                        none;
  logic                        overflow;

  modport source (output valid, dup_value, occurrences, final_res, none, overflow,
                  input ready);
  modport sink   (input valid, dup_value, occurrences, final_res, none, overflow,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/duplicate_value_counter_core.sv @@
// Loading: one element per cycle, in_ch.ready is high only while in the load state.
// Scan: after the last element, the probe wave crosses the cell row (each
// element's probe starts after its predecessor's), then the final result is
// issued; output stalls hold the scan.
// Reset (synchronous, active low) clears counters, flags and the result valid bit;
// stored element values are undefined until loaded.
`default_nettype none

`include "assert_macros.svh"

module duplicate_value_counter_core #(
  parameter int DEPTH = dvc_pkg::DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  dvc_in_if.sink    in_ch,
  dvc_out_if.source out_ch
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(2 * DEPTH);
  localparam logic [SW-1:0] STEP_LAST = SW'(2 * DEPTH - 1);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]    state_r;
  logic [1:0]    state_nxt;
  logic [CW-1:0] count_r;
  logic          ovf_r;
  logic [SW-1:0] step_cnt_r;

  logic               accept;
  logic               room;
  logic               out_free;
  logic               finish;
  dvc_pkg::cell_ctl_t ctl;

  logic [dvc_pkg::VALUE_W-1:0] val_chain [DEPTH+1];
  logic                        occ_chain [DEPTH+1];
  dvc_pkg::probe_t             prb_chain [DEPTH+1];
  logic [DEPTH-1:0]            launch;

  assign in_ch.ready = (state_r == ST_LOAD);
  assign accept      = in_ch.valid && in_ch.ready;
  assign room        = (count_r < CW'(DEPTH));
  assign finish      = (state_r == ST_FIN) && out_free;

  assign ctl.load  = accept && room;
  assign ctl.step  = (state_r == ST_SCAN) && out_free;
  assign ctl.clear = finish;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (accept && in_ch.last) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (ctl.step && (step_cnt_r == STEP_LAST)) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (finish) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      count_r    <= '0;
      ovf_r      <= 1'b0;
      step_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else if (accept) begin
        if (room) begin
          count_r <= count_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      // Advance the scan step; restart at each new set
      if (state_r == ST_LOAD) begin
        step_cnt_r <= '0;
      end else if (ctl.step) begin
        step_cnt_r <= step_cnt_r + SW'(1);
      end
    end
  end

  // Cell row: elements enter at the top end, probes leave at the top end
  assign val_chain[DEPTH] = in_ch.value;
  assign occ_chain[DEPTH] = 1'b1;
  assign prb_chain[0]     = '0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    assign launch[k] = ctl.step && (step_cnt_r == SW'(2 * k));

    dvc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .launch    (launch[k]),
      .nb_val    (val_chain[k+1]),
      .nb_occ    (occ_chain[k+1]),
      .probe_in  (prb_chain[k]),
      .val       (val_chain[k]),
      .occ       (occ_chain[k]),
      .probe_out (prb_chain[k+1])
    );
  end

  dvc_collect u_collect (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (ctl.step),
    .finish   (finish),
    .ovf      (ovf_r),
    .probe    (prb_chain[DEPTH]),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

  // Checks
  `DVC_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `DVC_ASSERT_NEXT(a_full_sets_ovf, accept && !room, ovf_r)
  `DVC_ASSERT_NEXT(a_fin_resets_set, finish,
                   (count_r == '0) && !ovf_r && (state_r == ST_LOAD))
  `DVC_ASSERT_NOW(a_one_launch, 1'b1, $onehot0(launch))

endmodule

`default_nettype wire

@@ rtl/core/dvc_cell.sv @@
`default_nettype none

module dvc_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire dvc_pkg::cell_ctl_t          ctl,
  input  wire logic                        launch,
  input  wire logic [dvc_pkg::VALUE_W-1:0] nb_val,
  input  wire logic                        nb_occ,
  input  wire dvc_pkg::probe_t             probe_in,
  output      logic [dvc_pkg::VALUE_W-1:0] val,
  output      logic                        occ,
  output      dvc_pkg::probe_t             probe_out
);

  logic [dvc_pkg::VALUE_W-1:0] val_r;
  logic                        occ_r;
  logic                        mark_r;
  logic                        mark_nxt;
  dvc_pkg::probe_t             probe_r;
  dvc_pkg::probe_t             probe_nxt;
  logic                        match;

  // Compare the passing probe against the held element
  assign match = probe_in.valid && occ_r && !mark_r && (probe_in.value == val_r);

  always_comb begin
    probe_nxt = probe_in;
    if (launch) begin
      // Start this element's own probe; marks are final by now
      probe_nxt.valid = occ_r && !mark_r && (val_r != '0);
      probe_nxt.value = val_r;
      probe_nxt.cnt   = dvc_pkg::OCC_W'(1);
    end else if (match && (probe_in.cnt != dvc_pkg::OCC_MAX)) begin
      probe_nxt.cnt = probe_in.cnt + dvc_pkg::OCC_W'(1);
    end
  end

  always_comb begin
    mark_nxt = mark_r;
    if (ctl.clear) begin
      mark_nxt = 1'b0;
    end else if (ctl.step && match) begin
      mark_nxt = 1'b1;
    end
  end

  // Shift element in from the upper neighbor while loading
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val_r <= nb_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= 1'b0;
      mark_r  <= 1'b0;
      probe_r <= '0;
    end else begin
      mark_r <= mark_nxt;
      if (ctl.clear) begin
        occ_r   <= 1'b0;
        probe_r <= '0;
      end else begin
        if (ctl.load) begin
          occ_r <= nb_occ;
        end
        if (ctl.step) begin
          probe_r <= probe_nxt;
        end
      end
    end
  end

  assign val       = val_r;
  assign occ       = occ_r;
  assign probe_out = probe_r;

endmodule

`default_nettype wire

@@ rtl/core/dvc_collect.sv @@
`default_nettype none

`include "assert_macros.svh"

module dvc_collect (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic            finish,
  input  wire logic            ovf,
  input  wire dvc_pkg::probe_t probe,
  output      logic            out_free,
  dvc_out_if.source            out_ch
);

  logic                        out_v_r;
  logic [dvc_pkg::VALUE_W-1:0] out_val_r;
  logic [dvc_pkg::OCC_W-1:0]   out_cnt_r;
  logic                        out_final_r;
  logic                        out_none_r;
  logic                        out_ovf_r;

  logic                        pend_v_r;
  logic [dvc_pkg::VALUE_W-1:0] pend_val_r;
  logic [dvc_pkg::OCC_W-1:0]   pend_cnt_r;
  logic [dvc_pkg::NRES_W-1:0]  nres_r;

  logic take;
  logic cand;
  logic push;

  assign take     = out_v_r && out_ch.ready;
  assign out_free = !out_v_r || out_ch.ready;

  // A probe leaving the row with more than one copy is a result
  assign cand = step && probe.valid && (probe.cnt > dvc_pkg::OCC_W'(1)) &&
                (nres_r < dvc_pkg::NRES_W'(dvc_pkg::MAX_RESULTS));
  assign push = cand && pend_v_r;

  // Hold one result back so the last one can carry the final flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      nres_r   <= '0;
    end else if (finish) begin
      pend_v_r <= 1'b0;
      nres_r   <= '0;
    end else if (cand) begin
      pend_v_r <= 1'b1;
      nres_r   <= nres_r + dvc_pkg::NRES_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cand) begin
      pend_val_r <= probe.value;
      pend_cnt_r <= probe.cnt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (push || finish) begin
      out_v_r <= 1'b1;
    end else if (take) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_val_r   <= pend_v_r ? pend_val_r : '0;
      out_cnt_r   <= pend_v_r ? pend_cnt_r : '0;
      out_final_r <= 1'b1;
      out_none_r  <= !pend_v_r;
      out_ovf_r   <= ovf;
    end else if (push) begin
      out_val_r   <= pend_val_r;
      out_cnt_r   <= pend_cnt_r;
      out_final_r <= 1'b0;
      out_none_r  <= 1'b0;
      out_ovf_r   <= ovf;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.dup_value   = out_val_r;
  assign out_ch.occurrences = out_cnt_r;
  assign out_ch.final_res   = out_final_r;
  assign out_ch.none        = out_none_r;
  assign out_ch.overflow    = out_ovf_r;

  // Checks
  `DVC_ASSERT_NOW(a_push_room, push || finish, out_free)
  `DVC_ASSERT_NEXT(a_finish_clears, finish, !pend_v_r && (nres_r == '0))
  `DVC_ASSERT_NOW(a_nres_limit, 1'b1,
                  nres_r <= dvc_pkg::NRES_W'(dvc_pkg::MAX_RESULTS))

endmodule

`default_nettype wire

@@ verif/tb_duplicate_value_counter_core.sv @@
`default_nettype none

module tb_duplicate_value_counter_core;

  localparam int DEPTH       = dvc_pkg::DEPTH_DEF;
  localparam int ITEM_TARGET = 410;
  localparam int CALM_AFTER  = 340;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN       = 2 * DEPTH + 40;
  localparam int LIMIT       = 200000;

  typedef logic [dvc_pkg::VALUE_W-1:0] word_t;
  typedef word_t word_q_t[$];

  typedef struct packed {
    logic [dvc_pkg::VALUE_W-1:0] dup_value;
    logic [dvc_pkg::OCC_W-1:0]   occurrences;
    logic                        final_res;
    logic                        none;
    logic                        overflow;
  } dup_result_t;

  // Predict the duplicate report of each set and check it against the DUT
  class dup_scoreboard;
    word_t         elements[DEPTH];
    int unsigned   fill;
    bit            dropped;
    dup_result_t   pending[$];
    int unsigned   mismatches;
    int unsigned   results_seen;
    int unsigned   sets_closed;
    int unsigned   overflow_sets;
    int unsigned   none_sets;

    function void note_request(word_t value, logic last);
      bit            marked[DEPTH];
      dup_result_t   found[$];
      dup_result_t   r;
      int unsigned   cnt;
      word_t         x;
      foreach (marked[k]) marked[k] = 1'b0;
      // Store the element, or drop it once the set is full
      if (fill < DEPTH) begin
        elements[fill] = value;
        fill++;
      end else begin
        dropped = 1'b1;
      end
      if (!last) return;
      // Scan in order, counting and marking later copies
      for (int i = 0; i < fill && found.size() < dvc_pkg::MAX_RESULTS; i++) begin
        x = elements[i];
        if (marked[i] || x == '0) continue;
        cnt = 1;
        for (int j = i + 1; j < fill; j++) begin
          if (!marked[j] && elements[j] == x) begin
            marked[j] = 1'b1;
            cnt++;
          end
        end
        if (cnt > 1) begin
          r.dup_value   = x;
          r.occurrences = (cnt > dvc_pkg::OCC_MAX) ? dvc_pkg::OCC_MAX
                                                   : cnt[dvc_pkg::OCC_W-1:0];
          r.final_res   = 1'b0;
          r.none        = 1'b0;
          r.overflow    = dropped;
          found.push_back(r);
        end
      end
      if (found.size() == 0) begin
        r = '0;
        r.final_res = 1'b1;
        r.none      = 1'b1;
        r.overflow  = dropped;
        found.push_back(r);
        none_sets++;
      end else begin
        found[found.size()-1].final_res = 1'b1;
      end
      foreach (found[k]) pending.push_back(found[k]);
      sets_closed++;
      if (dropped) overflow_sets++;
      fill    = 0;
      dropped = 1'b0;
    endfunction

    function void report(string what, dup_result_t want, dup_result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s: exp val=%h occ=%0d fin=%b none=%b ovf=%b", what,
                 want.dup_value, want.occurrences, want.final_res, want.none,
                 want.overflow);
        $display("    got val=%h occ=%0d fin=%b none=%b ovf=%b",
                 got.dup_value, got.occurrences, got.final_res, got.none,
                 got.overflow);
      end
    endfunction

    function void check_result(dup_result_t got);
      dup_result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = pending.pop_front();
      if (got.dup_value !== want.dup_value || got.occurrences !== want.occurrences ||
          got.final_res !== want.final_res || got.none !== want.none ||
          got.overflow !== want.overflow)
        report("result mismatch", want, got);
    endfunction

    // Count every expectation still waiting as a failure
    function void close_run();
      while (pending.size() != 0) report("missing result", pending.pop_front(), '0);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;
  bit   hold_req;
  int   items_sent;
  int   cycle_count;

  dvc_in_if  in_ch ();
  dvc_out_if out_ch ();

  dup_scoreboard sb = new;

  duplicate_value_counter_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on total run length
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Regression FAIL");
    $finish;
  end

  // Check each accepted result at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.dup_value, out_ch.occurrences, out_ch.final_res,
                        out_ch.none, out_ch.overflow});
  end

  // Result side: random ready bursts, one long hold on request
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready = 1'b0;
        n = $urandom_range(1, 7);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
        n = $urandom_range(1, 20);
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // Offer one request; entered and left at a falling edge
  task automatic send_item(word_t value, logic last);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.value = value;
    in_ch.last  = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(value, last);
    items_sent++;
    if (items_sent >= CALM_AFTER) calm = 1'b1;
    @(negedge clk);
  endtask

  task automatic send_set(word_q_t vals);
    foreach (vals[k]) send_item(vals[k], k == vals.size() - 1);
  endtask

  // Pick a value likely to repeat: zero, all ones, one-hot or random
  function automatic word_t pool_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(0, dvc_pkg::VALUE_W - 1);
      default: return $urandom;
    endcase
  endfunction

  // Small set drawn mostly from a short pool so that values repeat
  function automatic word_q_t small_set();
    word_q_t q;
    word_t   pool[4];
    int      size;
    int      pool_n;
    size   = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
    pool_n = $urandom_range(1, 4);
    for (int k = 0; k < pool_n; k++) pool[k] = pool_word();
    for (int k = 0; k < size; k++)
      q.push_back(($urandom_range(0, 2) != 0) ? pool[$urandom_range(0, pool_n - 1)]
                                              : word_t'($urandom));
    return q;
  endfunction

  // Full set of 32 distinct repeated pairs in random order
  function automatic word_q_t pairs_set();
    word_q_t q;
    word_t   v;
    word_t   tmp;
    int      j;
    for (int k = 0; k < DEPTH / 2; k++) begin
      v = $urandom;
      v[6:0] = {1'b1, 6'(k)};
      q.push_back(v);
      q.push_back(v);
    end
    for (int k = q.size() - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = q[k];
      q[k] = q[j];
      q[j] = tmp;
    end
    return q;
  endfunction

  // Stimulus: directed sets, then random sets with a few full and overflowing ones
  initial begin
    word_q_t q;
    word_t   v;
    int      set_idx;
    int      extra;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.last  = 1'b0;
    rst_n       = 1'b0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    items_sent  = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Single element, all ones
    send_set('{32'hFFFF_FFFF});
    // Zeros ignored, two repeated values, unique tail
    send_set('{32'h0, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h1, 32'h1, 32'h5});
    // Only zeros repeat
    send_set('{32'h0, 32'h0});
    // No repeats at all
    send_set('{32'h7, 32'h8, 32'h9, 32'hA});
    // Complementary patterns, each twice
    send_set('{32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h5A5A_5A5A});

    set_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      q.delete();
      case (set_idx)
        2: begin
          // Hold the result side so the scan backs up and input stalls
          hold_req = 1'b1;
          q = pairs_set();
        end
        5: begin
          v = $urandom;
          if (v == '0) v = 32'h1;
          repeat (DEPTH) q.push_back(v);
        end
        8, 20: begin
          // Overflow: the tail, last element included, is dropped
          q = small_set();
          while (q.size() < DEPTH) q.push_back(q[$urandom_range(0, q.size() - 1)]);
          extra = $urandom_range(1, 6);
          repeat (extra) q.push_back(pool_word());
        end
        default: q = small_set();
      endcase
      send_set(q);
      set_idx++;
    end
    in_ch.valid = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    sb.close_run();

    $display("%0d requests in %0d sets (%0d overflowed, %0d with no repeat)",
             items_sent, sb.sets_closed, sb.overflow_sets, sb.none_sets);
    $display("%0d results checked, %0d mismatches", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
